// ===== hdl/x3pps_pkg.sv =====
// ----------------------------------------------------------------------------
// X.3 PAD parameter store - shared definitions
// Command and status codes, table control word and standard profiles.
// ----------------------------------------------------------------------------
package x3pps_pkg;

    localparam int unsigned PARAM_COUNT = 30;
    localparam logic [7:0]  PROFILE_ID_SIMPLE      = 8'd90;
    localparam logic [7:0]  PROFILE_ID_TRANSPARENT = 8'd91;
    localparam int unsigned SPEED_REF      = 11;
    localparam logic [7:0]  SPEED_CODE_MAX = 8'd19;

    typedef enum logic [1:0] {
        CMD_LOAD_PROFILE = 2'd0,
        CMD_READ         = 2'd1,
        CMD_WRITE        = 2'd2,
        CMD_SET_SPEED    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_REF     = 3'd1,
        ST_BAD_VALUE   = 3'd2,
        ST_READ_ONLY   = 3'd3,
        ST_BAD_PROFILE = 3'd4
    } t_status;

    typedef struct packed {
        logic       load_en;
        logic       load_transparent;
        logic       wr_en;
        logic [4:0] wr_idx;
        logic [7:0] wr_data;
    } t_tbl_ctrl;

    localparam logic [7:0] PROF_SIMPLE [0:PARAM_COUNT-1] = '{
        8'd1, 8'd1, 8'd126, 8'd0, 8'd1, 8'd1, 8'd2, 8'd0, 8'd0, 8'd0,
        8'd14, 8'd1, 8'd0, 8'd0, 8'd0, 8'd127, 8'd24, 8'd18, 8'd1, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam logic [7:0] PROF_TRANSPARENT [0:PARAM_COUNT-1] = '{
        8'd0, 8'd0, 8'd0, 8'd20, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0,
        8'd14, 8'd0, 8'd0, 8'd0, 8'd0, 8'd127, 8'd24, 8'd18, 8'd1, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

endpackage

// ===== hdl/x3_pad_parameter_store_core.sv =====
// ----------------------------------------------------------------------------
// X.3 PAD parameter store - top level
// Request/response store for the 30 X.3 PAD parameters.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: the command in tuser, the
//   reference, value and profile id in tdata. Each request returns one
//   response word on m_axis: status and read data.
//   A request is captured in an input register and executed combinationally
//   against the flop table (check, read, write or profile load); its response
//   lands in the output register, which drives m_axis_tvalid.
//   Throughput is one request per cycle while the receiver takes each response;
//   the limit is the single execute stage between the input and output registers.
//   When the receiver stalls, the output register holds its word and the
//   input register holds the pending request; s_axis_tready drops only
//   when both are full.
//   Reset clears both valid flags and every table entry to zero.
// ----------------------------------------------------------------------------
module x3_pad_parameter_store_core #(
    parameter int unsigned NUM_PARAMS = x3pps_pkg::PARAM_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // param_ref[7:0], param_value[15:8], profile_select[23:16]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status[2:0], read_value[10:3]
);
    import x3pps_pkg::*;

    logic       r_in_valid;
    t_cmd       r_cmd;
    logic [7:0] r_ref;
    logic [7:0] r_val;
    logic [7:0] r_prof;

    logic       r_out_valid;
    t_status    r_status;
    logic [7:0] r_rdata;

    logic       advance;
    logic       fire;
    logic       in_take;
    logic [4:0] rd_idx;
    logic [7:0] rd_data;
    t_tbl_ctrl  tbl_ctrl;
    t_status    n_status;
    logic [7:0] n_rdata;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd  <= t_cmd'(s_axis_tuser);
            r_ref  <= s_axis_tdata[7:0];
            r_val  <= s_axis_tdata[15:8];
            r_prof <= s_axis_tdata[23:16];
        end
    end

    x3pps_exec #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_exec (
        .i_valid          (fire),
        .i_cmd            (r_cmd),
        .i_param_ref      (r_ref),
        .i_param_value    (r_val),
        .i_profile_select (r_prof),
        .i_rd_data        (rd_data),
        .o_rd_idx         (rd_idx),
        .o_ctrl           (tbl_ctrl),
        .o_status         (n_status),
        .o_read_value     (n_rdata)
    );

    x3pps_table #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (tbl_ctrl),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
            r_rdata  <= n_rdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_rdata, r_status};

endmodule

// ===== hdl/x3pps_table.sv =====
// ----------------------------------------------------------------------------
// X.3 PAD parameter store - parameter table
// Flop table with whole-table profile load, single write and one read port.
// ----------------------------------------------------------------------------
module x3pps_table #(
    parameter int unsigned NUM_PARAMS = x3pps_pkg::PARAM_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  x3pps_pkg::t_tbl_ctrl  i_ctrl,
    input  logic [4:0]            i_rd_idx,
    output logic [7:0]            o_rd_data
);
    import x3pps_pkg::*;

    logic [7:0] r_tbl [0:NUM_PARAMS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PARAMS; k++) begin
                r_tbl[k] <= '0;
            end
        end else if (i_ctrl.load_en) begin
            for (int k = 0; k < NUM_PARAMS; k++) begin
                r_tbl[k] <= i_ctrl.load_transparent ? PROF_TRANSPARENT[k] : PROF_SIMPLE[k];
            end
        end else if (i_ctrl.wr_en) begin
            r_tbl[i_ctrl.wr_idx] <= i_ctrl.wr_data;
        end
    end

    assign o_rd_data = (32'(i_rd_idx) < NUM_PARAMS) ? r_tbl[i_rd_idx] : '0;

endmodule

// ===== hdl/x3pps_exec.sv =====
// ----------------------------------------------------------------------------
// X.3 PAD parameter store - command execution
// Decodes one request, checks reference, value and profile id, drives table control.
// ----------------------------------------------------------------------------
module x3pps_exec #(
    parameter int unsigned NUM_PARAMS = x3pps_pkg::PARAM_COUNT
) (
    input  logic                  i_valid,
    input  x3pps_pkg::t_cmd       i_cmd,
    input  logic [7:0]            i_param_ref,
    input  logic [7:0]            i_param_value,
    input  logic [7:0]            i_profile_select,
    input  logic [7:0]            i_rd_data,
    output logic [4:0]            o_rd_idx,
    output x3pps_pkg::t_tbl_ctrl  o_ctrl,
    output x3pps_pkg::t_status    o_status,
    output logic [7:0]            o_read_value
);
    import x3pps_pkg::*;

    function automatic t_status check_value(input logic [7:0] r, input logic [7:0] v);
        logic ok;
        logic prn;
        prn = (v >= 8'd32) && (v <= 8'd126);
        ok  = 1'b1;
        unique case (r)
            8'd1:  ok = (v <= 8'd1) || prn;
            8'd2:  ok = (v <= 8'd2) || prn;
            8'd3:  ok = v <= 8'd127;
            8'd5:  ok = v <= 8'd2;
            8'd7:  ok = v <= 8'd31;
            8'd8:  ok = v <= 8'd1;
            8'd12: ok = v <= 8'd1;
            8'd13: ok = v <= 8'd7;
            8'd15: ok = v <= 8'd1;
            8'd16: ok = v <= 8'd130;
            8'd17: ok = v <= 8'd127;
            8'd18: ok = v <= 8'd127;
            8'd19: ok = (v <= 8'd2) || (v == 8'd8) || prn;
            8'd21: ok = v <= 8'd4;
            8'd24: ok = v <= 8'd127;
            8'd25: ok = v <= 8'd63;
            8'd26: ok = v <= 8'd1;
            8'd27: ok = v <= 8'd1;
            8'd28: ok = v <= 8'd1;
            8'd30: ok = v <= 8'd12;
            default: ok = 1'b1;
        endcase
        if (r == 8'(SPEED_REF)) begin
            return ST_READ_ONLY;
        end
        return ok ? ST_OK : ST_BAD_VALUE;
    endfunction

    logic    ref_ok;
    t_status wr_chk;

    assign ref_ok   = (i_param_ref >= 8'd1) && (i_param_ref <= 8'(NUM_PARAMS));
    assign o_rd_idx = 5'(i_param_ref - 8'd1);
    assign wr_chk   = check_value(i_param_ref, i_param_value);

    always_comb begin
        o_ctrl           = '0;
        o_ctrl.wr_idx    = o_rd_idx;
        o_ctrl.wr_data   = i_param_value;
        o_status         = ST_OK;
        o_read_value     = '0;
        unique case (i_cmd)
            CMD_LOAD_PROFILE: begin
                if (i_profile_select == PROFILE_ID_SIMPLE) begin
                    o_ctrl.load_en = i_valid;
                end else if (i_profile_select == PROFILE_ID_TRANSPARENT) begin
                    o_ctrl.load_en          = i_valid;
                    o_ctrl.load_transparent = 1'b1;
                end else begin
                    o_status = ST_BAD_PROFILE;
                end
            end
            CMD_READ: begin
                if (ref_ok) begin
                    o_read_value = i_rd_data;
                end else begin
                    o_status = ST_BAD_REF;
                end
            end
            CMD_WRITE: begin
                if (!ref_ok) begin
                    o_status = ST_BAD_REF;
                end else begin
                    o_status     = wr_chk;
                    o_ctrl.wr_en = i_valid && (wr_chk == ST_OK);
                end
            end
            CMD_SET_SPEED: begin
                o_ctrl.wr_idx = 5'(SPEED_REF - 1);
                if (i_param_value > SPEED_CODE_MAX) begin
                    o_status = ST_BAD_VALUE;
                end else begin
                    o_ctrl.wr_en = i_valid;
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

endmodule
